[rtl/fmws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmws_pkg
// Widths, register codes, state encoding and shared types of the flow
// magnitude window statistics unit.
// ----------------------------------------------------------------------------
package fmws_pkg;

    localparam int POS_W      = 16;  // Q12.4 position
    localparam int MAG_W      = 17;  // Q.4 magnitude
    localparam int RAD_W      = 34;  // padded dx^2 + dy^2
    localparam int CNT_W      = 9;
    localparam int SUM_W      = 25;
    localparam int SQS_W      = 42;
    localparam int MEAN_W     = 17;
    localparam int VAR_W      = 34;
    localparam int WMEAN_W    = 23;
    localparam int WVAR_W     = 40;
    localparam int WMAX_W     = 23;
    localparam int WLEN_W     = 7;
    localparam int CFG_DATA_W = 34;
    localparam int CFG_IDX_W  = 1;
    localparam int NUM_W      = 52;  // variance numerator
    localparam int DEN_W      = 17;  // n*n

    localparam int MAX_POINTS      = 256;
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int WLEN_RESET      = 15;
    localparam logic [VAR_W-1:0] VAR_LIMIT_RESET = 34'd51200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LEN = 1'b0,
        REG_VAR_LIMIT  = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_ACCUM,
        S_PRODUCT,
        S_NUMER,
        S_DIV_MEAN,
        S_DIV_VAR,
        S_JUDGE,
        S_WINDOW
    } fmws_state_t;

    typedef struct packed {
        logic clear;
        logic rd_en;
        logic wr_en;
    } ring_ctrl_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]  fvar;
        logic [MAG_W-1:0]  peak;
    } ring_entry_t;

endpackage

[rtl/fmws_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmws_if
// Point and result channels: valid/ready with payload.
// ----------------------------------------------------------------------------
interface fmws_point_if
    import fmws_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] prev_x;
    logic [POS_W-1:0] prev_y;
    logic [POS_W-1:0] curr_x;
    logic [POS_W-1:0] curr_y;
    logic             tracked;
    logic             last_point;

    modport source (output valid, prev_x, prev_y, curr_x, curr_y, tracked, last_point,
                    input ready);
    modport sink   (input valid, prev_x, prev_y, curr_x, curr_y, tracked, last_point,
                    output ready);
endinterface

interface fmws_result_if
    import fmws_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MEAN_W-1:0]  frame_mean;
    logic [VAR_W-1:0]   frame_var;
    logic [MAG_W-1:0]   frame_max;
    logic               disorder;
    logic [CNT_W-1:0]   point_count;
    logic [WMEAN_W-1:0] window_mean_sum;
    logic [WVAR_W-1:0]  window_var_sum;
    logic [WMAX_W-1:0]  window_max_sum;

    modport source (output valid, frame_mean, frame_var, frame_max, disorder, point_count,
                    window_mean_sum, window_var_sum, window_max_sum, input ready);
    modport sink   (input valid, frame_mean, frame_var, frame_max, disorder, point_count,
                    window_mean_sum, window_var_sum, window_max_sum, output ready);
endinterface

[rtl/fmws_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmws_sqrt
// Floor square root, one result bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
module fmws_sqrt
    import fmws_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RAD_W-1:0] rad,
    output logic             done,
    output logic [MAG_W-1:0] root
);
    localparam int CW = $clog2(MAG_W + 1);

    logic [RAD_W-1:0] rad_reg;
    logic [MAG_W+1:0] rem_reg;
    logic [MAG_W-1:0] root_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [MAG_W+1:0] rem_sh;
    logic [MAG_W+1:0] trial;
    logic             ge;

    always_comb
    begin
        rem_sh = {rem_reg[MAG_W-1:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial  = {1'b0, root_reg[MAG_W-2:0], 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[MAG_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[rtl/fmws_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmws_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fmws_div
    import fmws_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, q_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[rtl/fmws_ring.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmws_ring
// History memory of past frame statistics with per-entry valid bits.
// ----------------------------------------------------------------------------
module fmws_ring
    import fmws_pkg::*;
#(
    parameter int DEPTH = WINDOW_MAX_DEF - 1,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ring_ctrl_t       ctrl,
    input  logic [IDX_W-1:0] rd_idx,
    input  logic [IDX_W-1:0] wr_idx,
    input  ring_entry_t      wr_data,
    output ring_entry_t      rd_data
);
    ring_entry_t      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    ring_entry_t      rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= valid_reg[rd_idx] ? mem[rd_idx] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/flow_magnitude_window_stats_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_magnitude_window_stats_unit
// Per-frame flow magnitude statistics with sliding-window sums.
// ----------------------------------------------------------------------------
// Each point transfer carries a previous and current Q12.4 position. A tracked
// point (up to MAX_POINTS per frame) is taken, its deltas are squared, its
// magnitude is found in 17 steps of the bit-serial square root, and it is then
// accumulated; an untracked point is only taken. The point marked last closes
// the frame: the block then forms products, runs two 52-step serial divisions
// for mean and variance (skipped for a frame with no tracked points), checks
// the limit and updates the history before the result transfer is offered
// and new points are taken. A finished result sits in an output register, so
// the next frame may start while it waits. A variance above var_limit zeroes
// mean, variance and max and sets disorder.
// Window sums cover the last window_len frames; a write to window_len clears
// the history at once through valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module flow_magnitude_window_stats_unit
    import fmws_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    fmws_point_if.sink            point,
    fmws_result_if.source         result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int DEPTH = WINDOW_MAX - 1;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = 8;   // window length arithmetic, holds WINDOW_MAX-1
    localparam logic [WLEN_W-1:0] WLEN_INIT =
        WLEN_W'((WINDOW_MAX < WLEN_RESET) ? WINDOW_MAX : WLEN_RESET);

    fmws_state_t state_reg, state_next;

    // configuration
    logic [WLEN_W-1:0] wlen_reg;
    logic [VAR_W-1:0]  var_limit_reg;
    logic [WLEN_W-1:0] wlen_wr;
    logic              clr_window;

    // current point
    logic [POS_W-1:0]  dx_reg, dy_reg;
    logic              use_reg, last_reg;

    // frame accumulators
    logic [SUM_W-1:0]  sum_reg;
    logic [SQS_W-1:0]  sqs_reg;
    logic [MAG_W-1:0]  peak_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // frame close
    logic [NUM_W-1:0]  prod_a_reg, prod_b_reg, num_reg;
    logic [DEN_W-1:0]  nn_reg;
    logic [MEAN_W-1:0] mean_q_reg;
    logic [VAR_W-1:0]  var_q_reg;
    ring_entry_t       frame_reg;
    logic              dis_reg;

    // window history
    logic [IDX_W-1:0]   ring_index_reg;
    logic [WMEAN_W-1:0] mean_acc_reg;
    logic [WVAR_W-1:0]  var_acc_reg;
    logic [WMAX_W-1:0]  max_acc_reg;
    logic [LW-1:0]      len8, idx8, nxt8;
    logic [IDX_W-1:0]   cur_idx, idx_next;
    logic               ring_active;
    ring_ctrl_t         ring_ctrl;
    ring_entry_t        old_ent;

    // output register
    logic               out_valid_reg;
    logic [MEAN_W-1:0]  o_mean_reg;
    logic [VAR_W-1:0]   o_var_reg;
    logic [MAG_W-1:0]   o_max_reg;
    logic               o_dis_reg;
    logic [CNT_W-1:0]   o_cnt_reg;
    logic [WMEAN_W-1:0] o_wmean_reg;
    logic [WVAR_W-1:0]  o_wvar_reg;
    logic [WMAX_W-1:0]  o_wmax_reg;

    // control
    logic               accept;
    logic               load_out;
    logic               root_start, root_done;
    logic [RAD_W-1:0]   rad;
    logic [MAG_W-1:0]   mag;
    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_num, quotient;
    logic [DEN_W-1:0]   div_den;

    assign accept   = point.valid && point.ready;
    assign load_out = (state_reg == S_WINDOW) && (!out_valid_reg || result.ready);

    // ---- configuration port ----
    always_comb
    begin
        wlen_wr = cfg_data[WLEN_W-1:0];
        if (wlen_wr == '0)
        begin
            wlen_wr = WLEN_W'(1);
        end
        else if (int'(wlen_wr) > WINDOW_MAX)
        begin
            wlen_wr = WLEN_W'(WINDOW_MAX);
        end
    end

    assign clr_window = cfg_wr_en && (cfg_idx == REG_WINDOW_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= WLEN_INIT;
            var_limit_reg <= VAR_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_idx))
                REG_WINDOW_LEN: wlen_reg      <= wlen_wr;
                REG_VAR_LIMIT:  var_limit_reg <= cfg_data[VAR_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---- ring slot for this frame ----
    always_comb
    begin
        len8        = LW'(wlen_reg) - LW'(1);
        idx8        = LW'(ring_index_reg);
        ring_active = (len8 != '0);
        cur_idx     = (idx8 >= len8) ? '0 : ring_index_reg;
        nxt8        = LW'(cur_idx) + LW'(1);
        idx_next    = (nxt8 >= len8) ? '0 : IDX_W'(nxt8);
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        point.ready = 1'b0;
        root_start = 1'b0;
        div_start  = 1'b0;
        div_num    = num_reg;
        div_den    = nn_reg;
        ring_ctrl  = '{clear: clr_window, rd_en: 1'b0, wr_en: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                point.ready = 1'b1;
                if (point.valid)
                begin
                    if (point.tracked && (cnt_reg < CNT_W'(MAX_POINTS)))
                        state_next = S_SQUARE;
                    else if (point.last_point)
                        state_next = S_PRODUCT;
                end
            end
            S_SQUARE:
            begin
                root_start = 1'b1;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (root_done)
                    state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                state_next = last_reg ? S_PRODUCT : S_IDLE;
            end
            S_PRODUCT:
            begin
                state_next = S_NUMER;
            end
            S_NUMER:
            begin
                // mean division needs only the sum; start it now
                div_num = NUM_W'(sum_reg);
                div_den = DEN_W'(cnt_reg);
                if (cnt_reg == '0)
                begin
                    state_next = S_JUDGE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV_MEAN;
                end
            end
            S_DIV_MEAN:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV_VAR;
                end
            end
            S_DIV_VAR:
            begin
                if (div_done)
                    state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                ring_ctrl.rd_en = 1'b1;
                state_next = S_WINDOW;
            end
            S_WINDOW:
            begin
                if (load_out)
                begin
                    ring_ctrl.wr_en = ring_active && !clr_window;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // ---- point path ----
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg   <= (point.curr_x >= point.prev_x) ? point.curr_x - point.prev_x
                                                       : point.prev_x - point.curr_x;
            dy_reg   <= (point.curr_y >= point.prev_y) ? point.curr_y - point.prev_y
                                                       : point.prev_y - point.curr_y;
            use_reg  <= point.tracked && (cnt_reg < CNT_W'(MAX_POINTS));
            last_reg <= point.last_point;
        end
    end

    assign rad = RAD_W'(32'(dx_reg) * 32'(dx_reg)) + RAD_W'(32'(dy_reg) * 32'(dy_reg));

    fmws_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .rad   (rad),
        .done  (root_done),
        .root  (mag)
    );

    // frame accumulators, cleared as the result is loaded into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            sqs_reg  <= '0;
            peak_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (state_reg == S_ACCUM && use_reg)
        begin
            sum_reg  <= sum_reg + SUM_W'(mag);
            sqs_reg  <= sqs_reg + SQS_W'(34'(mag) * 34'(mag));
            peak_reg <= (mag > peak_reg) ? mag : peak_reg;
            cnt_reg  <= cnt_reg + 1'b1;
        end
        else if (load_out)
        begin
            sum_reg  <= '0;
            sqs_reg  <= '0;
            peak_reg <= '0;
            cnt_reg  <= '0;
        end
    end

    // ---- frame close ----
    fmws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_PRODUCT:
            begin
                prod_a_reg <= NUM_W'(cnt_reg) * NUM_W'(sqs_reg);
                prod_b_reg <= NUM_W'(sum_reg) * NUM_W'(sum_reg);
                nn_reg     <= DEN_W'(cnt_reg) * DEN_W'(cnt_reg);
            end
            S_NUMER:
            begin
                // n*sum(m^2) >= sum(m)^2, so this never goes negative
                num_reg    <= prod_a_reg - prod_b_reg;
                mean_q_reg <= '0;
                var_q_reg  <= '0;
            end
            S_DIV_MEAN:
            begin
                if (div_done)
                    mean_q_reg <= quotient[MEAN_W-1:0];
            end
            S_DIV_VAR:
            begin
                if (div_done)
                    var_q_reg <= (|quotient[NUM_W-1:VAR_W]) ? '1 : quotient[VAR_W-1:0];
            end
            S_JUDGE:
            begin
                dis_reg <= (var_q_reg > var_limit_reg);
                if (var_q_reg > var_limit_reg)
                    frame_reg <= '0;
                else
                    frame_reg <= '{mean: mean_q_reg, fvar: var_q_reg, peak: peak_reg};
            end
            default: ;
        endcase
    end

    fmws_ring #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ring_ctrl),
        .rd_idx  (cur_idx),
        .wr_idx  (cur_idx),
        .wr_data (frame_reg),
        .rd_data (old_ent)
    );

    // window sums: a window_len write wins over a frame update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_index_reg <= '0;
            mean_acc_reg   <= '0;
            var_acc_reg    <= '0;
            max_acc_reg    <= '0;
        end
        else if (clr_window)
        begin
            ring_index_reg <= '0;
            mean_acc_reg   <= '0;
            var_acc_reg    <= '0;
            max_acc_reg    <= '0;
        end
        else if (load_out && ring_active)
        begin
            ring_index_reg <= idx_next;
            mean_acc_reg   <= mean_acc_reg + WMEAN_W'(frame_reg.mean) - WMEAN_W'(old_ent.mean);
            var_acc_reg    <= var_acc_reg + WVAR_W'(frame_reg.fvar) - WVAR_W'(old_ent.fvar);
            max_acc_reg    <= max_acc_reg + WMAX_W'(frame_reg.peak) - WMAX_W'(old_ent.peak);
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_mean_reg  <= frame_reg.mean;
            o_var_reg   <= frame_reg.fvar;
            o_max_reg   <= frame_reg.peak;
            o_dis_reg   <= dis_reg;
            o_cnt_reg   <= cnt_reg;
            o_wmean_reg <= mean_acc_reg + WMEAN_W'(frame_reg.mean);
            o_wvar_reg  <= var_acc_reg + WVAR_W'(frame_reg.fvar);
            o_wmax_reg  <= max_acc_reg + WMAX_W'(frame_reg.peak);
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.frame_mean      = o_mean_reg;
    assign result.frame_var       = o_var_reg;
    assign result.frame_max       = o_max_reg;
    assign result.disorder        = o_dis_reg;
    assign result.point_count     = o_cnt_reg;
    assign result.window_mean_sum = o_wmean_reg;
    assign result.window_var_sum  = o_wvar_reg;
    assign result.window_max_sum  = o_wmax_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above limit");

    a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> state_reg == S_ROOT)
        else $error("square root finished outside its wait state");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_MEAN || state_reg == S_DIV_VAR))
        else $error("division finished outside its wait states");

    a_wlen_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_window |=> (ring_index_reg == '0 && mean_acc_reg == '0
                        && var_acc_reg == '0 && max_acc_reg == '0))
        else $error("window_len write did not clear history");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result load lost");
`endif

endmodule

[sim/flow_magnitude_window_stats_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_magnitude_window_stats_unit_tb
// Drives point frames into the flow magnitude statistics unit and compares
// every result against an in-bench predictor of magnitudes, frame statistics
// and sliding-window sums, under random idling on both channels.
// ----------------------------------------------------------------------------
module flow_magnitude_window_stats_unit_tb;
    import fmws_pkg::*;

    localparam int RING_D    = WINDOW_MAX_DEF - 1;
    localparam int CYC_LIMIT = 2000000;
    localparam int SETTLE    = 300;   // post-frame work of the block, with margin
    localparam int EXP_DEPTH = 16;    // expected results in flight, well above need

    // one frame result as the block should present it
    typedef struct packed {
        logic [MEAN_W-1:0]  frame_mean;
        logic [VAR_W-1:0]   frame_var;
        logic [MAG_W-1:0]   frame_max;
        logic               disorder;
        logic [CNT_W-1:0]   point_count;
        logic [WMEAN_W-1:0] window_mean_sum;
        logic [WVAR_W-1:0]  window_var_sum;
        logic [WMAX_W-1:0]  window_max_sum;
    } frame_stats_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    fmws_point_if  point();
    fmws_result_if result();

    flow_magnitude_window_stats_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .point    (point),
        .result   (result),
        .cfg_wr_en(cfg_wr_en),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // predictor state
    int unsigned       win_len;
    logic [VAR_W-1:0]  lim_var;
    logic [SUM_W-1:0]  acc_sum;
    logic [SQS_W-1:0]  acc_sq;
    logic [MAG_W-1:0]  acc_peak;
    int unsigned       acc_n;
    logic [MEAN_W-1:0] hist_mean [RING_D];
    logic [VAR_W-1:0]  hist_var  [RING_D];
    logic [MAG_W-1:0]  hist_peak [RING_D];
    int unsigned       hist_pos;
    logic [WMEAN_W-1:0] wsum_mean;
    logic [WVAR_W-1:0]  wsum_var;
    logic [WMAX_W-1:0]  wsum_peak;

    // expected results, written by the predictor, read by the checker
    frame_stats_t exp_fifo [EXP_DEPTH];
    int  exp_wr;
    int  exp_rd;
    int  errors;
    int  cycles;
    int  idle_pct;        // chance in percent of a gap on each side
    bit  hold_results;    // long receiver hold-off
    int  hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [MAG_W-1:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res[MAG_W-1:0];
    endfunction

    task automatic clear_history();
        for (int i = 0; i < RING_D; i++)
        begin
            hist_mean[i] = '0;
            hist_var[i]  = '0;
            hist_peak[i] = '0;
        end
        hist_pos  = 0;
        wsum_mean = '0;
        wsum_var  = '0;
        wsum_peak = '0;
    endtask

    // Fold one accepted point into the frame; on the last point queue the result.
    task automatic predict_point(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                                 input logic [POS_W-1:0] cx, input logic [POS_W-1:0] cy,
                                 input bit trk, input bit lst);
        logic [63:0] dx, dy, num, q, mean, fvar, peak;
        logic [MAG_W-1:0] mag;
        frame_stats_t s;
        int unsigned len, i;
        bit dis;
        if (trk && acc_n < MAX_POINTS)
        begin
            dx = (cx >= px) ? cx - px : px - cx;
            dy = (cy >= py) ? cy - py : py - cy;
            mag = isqrt(dx * dx + dy * dy);
            acc_sum  = acc_sum + mag;
            acc_sq   = acc_sq + mag * mag;
            if (mag > acc_peak) acc_peak = mag;
            acc_n++;
        end
        if (!lst) return;
        mean = 0;
        fvar = 0;
        dis  = 0;
        peak = acc_peak;
        if (acc_n != 0)
        begin
            num  = 64'(acc_n) * 64'(acc_sq) - 64'(acc_sum) * 64'(acc_sum);
            mean = (64'(acc_sum) / acc_n) & ((64'd1 << MEAN_W) - 1);
            q    = num / (64'(acc_n) * acc_n);
            fvar = (q > ((64'd1 << VAR_W) - 1)) ? ((64'd1 << VAR_W) - 1) : q;
        end
        if (fvar > lim_var)
        begin
            // disorder: statistics zeroed before they enter the window
            dis = 1;
            mean = 0;
            fvar = 0;
            peak = 0;
        end
        s.frame_mean      = mean[MEAN_W-1:0];
        s.frame_var       = fvar[VAR_W-1:0];
        s.frame_max       = peak[MAG_W-1:0];
        s.disorder        = dis;
        s.point_count     = acc_n[CNT_W-1:0];
        s.window_mean_sum = wsum_mean + mean[WMEAN_W-1:0];
        s.window_var_sum  = wsum_var + fvar[WVAR_W-1:0];
        s.window_max_sum  = wsum_peak + peak[WMAX_W-1:0];
        len = win_len - 1;
        if (len > 0)
        begin
            i = (hist_pos >= len) ? 0 : hist_pos;
            wsum_mean = wsum_mean + mean[WMEAN_W-1:0] - hist_mean[i];
            wsum_var  = wsum_var + fvar[WVAR_W-1:0] - hist_var[i];
            wsum_peak = wsum_peak + peak[WMAX_W-1:0] - hist_peak[i];
            hist_mean[i] = mean[MEAN_W-1:0];
            hist_var[i]  = fvar[VAR_W-1:0];
            hist_peak[i] = peak[MAG_W-1:0];
            i++;
            hist_pos = (i >= len) ? 0 : i;
        end
        exp_fifo[exp_wr % EXP_DEPTH] = s;
        exp_wr++;
        acc_sum  = '0;
        acc_sq   = '0;
        acc_peak = '0;
        acc_n    = 0;
    endtask

    // one point transfer; predictor updated when it is accepted. valid stays
    // high afterwards: the next call or drain() sets it in the same step.
    task automatic send_point(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                              input logic [POS_W-1:0] cx, input logic [POS_W-1:0] cy,
                              input bit trk, input bit lst);
        while ($urandom_range(99) < idle_pct)
        begin
            point.valid <= 1'b0;
            @(posedge clk);
        end
        point.valid      <= 1'b1;
        point.prev_x     <= px;
        point.prev_y     <= py;
        point.curr_x     <= cx;
        point.curr_y     <= cy;
        point.tracked    <= trk;
        point.last_point <= lst;
        @(posedge clk);
        while (!point.ready) @(posedge clk);
        predict_point(px, py, cx, cy, trk, lst);
    endtask

    // result side: random ready, long hold-off on request
    always @(posedge clk)
    begin
        if (hold_results && hold_cycles > 0)
        begin
            result.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end
        else
            result.ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        frame_stats_t e;
        frame_stats_t a;
        if (rst_n && result.valid && result.ready)
        begin
            a.frame_mean      = result.frame_mean;
            a.frame_var       = result.frame_var;
            a.frame_max       = result.frame_max;
            a.disorder        = result.disorder;
            a.point_count     = result.point_count;
            a.window_mean_sum = result.window_mean_sum;
            a.window_var_sum  = result.window_var_sum;
            a.window_max_sum  = result.window_max_sum;
            if (exp_wr == exp_rd)
            begin
                $display("%0t: unexpected result %p", $time, a);
                errors++;
            end
            else
            begin
                e = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (a.frame_mean !== e.frame_mean)
                begin
                    $display("%0t: frame_mean exp %0d got %0d", $time, e.frame_mean, a.frame_mean);
                    errors++;
                end
                if (a.frame_var !== e.frame_var)
                begin
                    $display("%0t: frame_var exp %0d got %0d", $time, e.frame_var, a.frame_var);
                    errors++;
                end
                if (a.frame_max !== e.frame_max)
                begin
                    $display("%0t: frame_max exp %0d got %0d", $time, e.frame_max, a.frame_max);
                    errors++;
                end
                if (a.disorder !== e.disorder)
                begin
                    $display("%0t: disorder exp %0d got %0d", $time, e.disorder, a.disorder);
                    errors++;
                end
                if (a.point_count !== e.point_count)
                begin
                    $display("%0t: point_count exp %0d got %0d", $time, e.point_count,
                             a.point_count);
                    errors++;
                end
                if (a.window_mean_sum !== e.window_mean_sum)
                begin
                    $display("%0t: window_mean_sum exp %0d got %0d", $time, e.window_mean_sum,
                             a.window_mean_sum);
                    errors++;
                end
                if (a.window_var_sum !== e.window_var_sum)
                begin
                    $display("%0t: window_var_sum exp %0d got %0d", $time, e.window_var_sum,
                             a.window_var_sum);
                    errors++;
                end
                if (a.window_max_sum !== e.window_max_sum)
                begin
                    $display("%0t: window_max_sum exp %0d got %0d", $time, e.window_max_sum,
                             a.window_max_sum);
                    errors++;
                end
            end
        end
    end

    // wait for all results, then let the block fall idle before a register write
    task automatic drain();
        point.valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        logic [63:0] v;
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx == REG_WINDOW_LEN)
        begin
            v = val & 7'h7f;
            if (v < 1) v = 1;
            if (v > WINDOW_MAX_DEF) v = WINDOW_MAX_DEF;
            win_len = v;
            clear_history();
        end
        else
            lim_var = val;
    endtask

    // random point whose motion stays below about mot in Q.4 units
    task automatic send_motion(input int mot, input bit trk, input bit lst);
        logic [POS_W-1:0] px, py;
        px = $urandom;
        py = $urandom;
        send_point(px, py, px + POS_W'($urandom_range(2 * mot) - mot),
                   py + POS_W'($urandom_range(2 * mot) - mot), trk, lst);
    endtask

    task automatic send_frame(input int npts, input int mot);
        for (int i = 0; i < npts; i++)
            send_motion(mot, $urandom_range(9) != 0, i == npts - 1);
    endtask

    // field extremes, empty and untracked frames, full-scale motion
    task automatic test_directed();
        send_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1);
        send_point(16'h0000, 16'h0000, 16'hffff, 16'hffff, 1, 0);
        send_point(16'hffff, 16'hffff, 16'h0000, 16'h0000, 1, 0);
        send_point(16'hffff, 16'h0000, 16'h0000, 16'hffff, 1, 1);
        send_point(16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 0, 1);   // empty frame
        send_point(16'h0010, 16'h0020, 16'h0013, 16'h0024, 1, 0);
        send_point(16'hffff, 16'hffff, 16'hfff0, 16'hfff8, 1, 0);
        send_point(16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 0, 1);
        send_point(16'h8000, 16'h8000, 16'h8000, 16'h8001, 1, 1);
    endtask

    // more than MAX_POINTS tracked points in one frame
    task automatic test_point_overflow();
        for (int i = 0; i < MAX_POINTS + 6; i++)
            send_motion(40, 1, i == MAX_POINTS + 5);
    endtask

    // window length extremes, including the clamps for 0 and above range
    task automatic test_window_lengths();
        int lens[6] = '{0, 1, 2, 64, 127, 33};
        foreach (lens[k])
        begin
            drain();
            write_reg(REG_WINDOW_LEN, CFG_DATA_W'(lens[k]));
            for (int f = 0; f < (lens[k] > 40 ? 70 : 12); f++)
                send_frame($urandom_range(1, 3), 200);
        end
    endtask

    // var_limit extremes: every non-empty varied frame is disorder at 0
    task automatic test_var_limit();
        logic [CFG_DATA_W-1:0] lims[3] = '{34'd0, 34'h3_ffff_ffff, 34'd2000};
        foreach (lims[k])
        begin
            drain();
            write_reg(REG_VAR_LIMIT, lims[k]);
            for (int f = 0; f < 10; f++)
                send_frame($urandom_range(1, 5), k == 1 ? 30000 : 600);
        end
    endtask

    // receiver stalls for a long stretch while points keep coming
    task automatic test_backpressure();
        idle_pct = 0;
        hold_cycles  <= 3000;
        hold_results <= 1'b1;
        for (int f = 0; f < 6; f++)
            send_frame(3, 300);
        hold_results <= 1'b0;
        idle_pct = 35;
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        drain();
        write_reg(REG_WINDOW_LEN, CFG_DATA_W'(WLEN_RESET));
        write_reg(REG_VAR_LIMIT, VAR_LIMIT_RESET);
        while (sent < 1000)
        begin
            int n;
            n = $urandom_range(1, 12);
            // stretch with no idling in the middle
            idle_pct = (sent > 500 && sent < 700) ? 0 : 35;
            send_frame(n, $urandom_range(3) == 0 ? 4000 : 300);
            sent += n;
        end
        idle_pct = 35;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycles = 0;
        errors = 0;
        exp_wr = 0;
        exp_rd = 0;
        idle_pct = 35;
        hold_results = 1'b0;
        hold_cycles = 0;
        cfg_wr_en = 1'b0;
        cfg_idx = REG_WINDOW_LEN;
        cfg_data = '0;
        point.valid = 1'b0;
        point.prev_x = '0;
        point.prev_y = '0;
        point.curr_x = '0;
        point.curr_y = '0;
        point.tracked = 1'b0;
        point.last_point = 1'b0;
        result.ready = 1'b0;
        win_len = WLEN_RESET;
        lim_var = VAR_LIMIT_RESET;
        acc_sum = '0;
        acc_sq = '0;
        acc_peak = '0;
        acc_n = 0;
        clear_history();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_point_overflow();
        test_window_lengths();
        test_var_limit();
        test_backpressure();
        test_random();

        drain();
        if (errors == 0 && exp_wr == exp_rd)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
